/* hw/rtl/aff2d_pkg.sv */
// Package for the 2D affine transform engine: widths, command codes, queue item
// and result types, the CORDIC arctangent table and saturation helpers.
// Depends on nothing; every other file of the block but aff2d_if imports it.
package aff2d_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int ENTRY_WIDTH  = 48;
	localparam int CORDIC_STEPS = 16;

	localparam int ACC_W        = 2 * ENTRY_WIDTH + 2;
	localparam int MUL_CHUNK    = 16;
	localparam int NCHUNKS      = (ENTRY_WIDTH + MUL_CHUNK - 1) / MUL_CHUNK;
	localparam int CHUNK_IDX_W  = (NCHUNKS > 1) ? $clog2(NCHUNKS) : 1;
	localparam int PROD_W       = ENTRY_WIDTH + MUL_CHUNK;
	localparam int CW           = 34;
	localparam int STEP_W       = $clog2(CORDIC_STEPS);
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int SAT_W        = 72;
	localparam int Q_UP         = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
	localparam int Q_DN         = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;

	localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

	localparam logic [2:0] CMD_MAP       = 3'd0;
	localparam logic [2:0] CMD_TRANSLATE = 3'd1;
	localparam logic [2:0] CMD_ROTATE    = 3'd2;
	localparam logic [2:0] CMD_SCALE     = 3'd3;
	localparam logic [2:0] CMD_CONCAT    = 3'd4;
	localparam logic [2:0] CMD_IDENTITY  = 3'd5;

	typedef logic signed [ENTRY_WIDTH-1:0] entry_t;

	localparam entry_t ONE     = entry_t'(1) << FRAC_BITS;
	localparam entry_t ENT_MAX = {1'b0, {(ENTRY_WIDTH - 1){1'b1}}};
	localparam entry_t ENT_MIN = {1'b1, {(ENTRY_WIDTH - 1){1'b0}}};

	localparam entry_t [5:0] IDENT_M = {entry_t'(0), ONE, entry_t'(0), entry_t'(0),
		entry_t'(0), ONE};

	typedef enum logic [1:0] {
		OP_MAP   = 2'd0,
		OP_XFORM = 2'd1,
		OP_ROT   = 2'd2,
		OP_IDENT = 2'd3
	} op_t;

	typedef struct packed {
		op_t          op;
		logic [15:0]  angle;
		entry_t [5:0] n;
	} queue_item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic               clipped;
	} res_t;

	function automatic logic [31:0] atan_lut(input logic [4:0] idx);
		logic [31:0] r;
		unique case (idx)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

	function automatic entry_t sat_wide(input logic signed [SAT_W-1:0] v);
		logic hi_ones;
		logic hi_zeros;
		hi_ones  = &v[SAT_W-1:ENTRY_WIDTH-1];
		hi_zeros = ~(|v[SAT_W-1:ENTRY_WIDTH-1]);
		if (hi_ones || hi_zeros) begin
			return v[ENTRY_WIDTH-1:0];
		end
		return v[SAT_W-1] ? ENT_MIN : ENT_MAX;
	endfunction

	function automatic entry_t sat_acc(input logic signed [ACC_W-1:0] v);
		logic hi_ones;
		logic hi_zeros;
		hi_ones  = &v[ACC_W-1:ENTRY_WIDTH-1];
		hi_zeros = ~(|v[ACC_W-1:ENTRY_WIDTH-1]);
		if (hi_ones || hi_zeros) begin
			return v[ENTRY_WIDTH-1:0];
		end
		return v[ACC_W-1] ? ENT_MIN : ENT_MAX;
	endfunction

	function automatic entry_t from_q16(input logic signed [31:0] raw);
		logic signed [SAT_W-1:0] v;
		v = SAT_W'(raw);
		v = (v <<< Q_UP) >>> Q_DN;
		return sat_wide(v);
	endfunction

	function automatic entry_t from_int(input logic signed [15:0] raw);
		logic signed [SAT_W-1:0] v;
		v = SAT_W'(raw);
		v = v <<< FRAC_BITS;
		return sat_wide(v);
	endfunction

endpackage

/* hw/rtl/aff2d_if.sv */
// Channel interfaces of the affine transform engine: the command channel and
// the result channel, each with valid, ready and payload. No dependencies.
interface aff2d_cmd_if;
	logic               valid;
	logic               ready;
	logic [2:0]         command;
	logic signed [15:0] coord_x;
	logic signed [15:0] coord_y;
	logic [15:0]        angle;
	logic signed [31:0] scale_x;
	logic signed [31:0] scale_y;
	logic signed [31:0] other_a;
	logic signed [31:0] other_b;
	logic signed [31:0] other_c;
	logic signed [31:0] other_d;
	logic signed [31:0] other_e;
	logic signed [31:0] other_f;

	modport source (
		output valid, command, coord_x, coord_y, angle, scale_x, scale_y,
		output other_a, other_b, other_c, other_d, other_e, other_f,
		input  ready
	);
	modport sink (
		input  valid, command, coord_x, coord_y, angle, scale_x, scale_y,
		input  other_a, other_b, other_c, other_d, other_e, other_f,
		output ready
	);
endinterface

interface aff2d_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic               clipped;

	modport source (output valid, out_x, out_y, clipped, input ready);
	modport sink (input valid, out_x, out_y, clipped, output ready);
endinterface

/* hw/rtl/affine_transform_2d_engine.sv */
// Top level of the 2D affine transform engine: front end, command queue and
// back end. Depends on aff2d_pkg, aff2d_if, aff2d_front, aff2d_fifo, aff2d_back.
//
// The engine keeps a 2x3 affine matrix in signed fixed point (reset to
// identity) and takes one command per transaction: map a point, translate,
// rotate, scale, concatenate or reload identity; each update but the reload
// post-multiplies the current matrix. Only a map returns a result
// transaction. A two-entry queue lets the front end accept commands while
// the back end works. The back end forms each new entry on one shared 48x16
// multiplier, three partial products per term, two terms per entry; a
// rotate first runs the 16-step CORDIC, and an identity reload uses no
// multiplier.
module affine_transform_2d_engine (
	input  logic        clk,
	input  logic        arst_n,
	aff2d_cmd_if.sink   cmd,
	aff2d_res_if.source res
);
	import aff2d_pkg::*;

	logic        q_push;
	logic        q_pop;
	logic        q_full;
	logic        q_empty;
	queue_item_t q_in;
	queue_item_t q_out;
	res_t        res_data;

	aff2d_front u_front (
		.cmd    (cmd),
		.q_full (q_full),
		.q_push (q_push),
		.q_item (q_in)
	);

	aff2d_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.empty     (q_empty)
	);

	aff2d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_item    (q_out),
		.q_pop     (q_pop),
		.res_data  (res_data),
		.res_valid (res.valid),
		.res_ready (res.ready)
	);

	assign res.out_x   = res_data.out_x;
	assign res.out_y   = res_data.out_y;
	assign res.clipped = res_data.clipped;

	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> !q_empty)
		else $error("Back end popped an empty command queue.");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready && cmd.command == CMD_MAP |=> !q_empty)
		else $error("Accepted map transaction did not reach the command queue.");

	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !q_full)
		else $error("Front end pushed into a full command queue.");

endmodule

/* hw/rtl/aff2d_front.sv */
// Front end: accepts command transactions, drops unused codes and converts the
// operands into a queue item; the operand matrix is ready-made except for a
// rotate. Depends on aff2d_pkg and aff2d_cmd_if.
module aff2d_front (
	aff2d_cmd_if.sink              cmd,
	input  logic                   q_full,
	output logic                   q_push,
	output aff2d_pkg::queue_item_t q_item
);
	import aff2d_pkg::*;

	logic known;

	assign cmd.ready = !q_full;

	always_comb begin
		q_item.op    = OP_IDENT;
		q_item.angle = cmd.angle;
		q_item.n     = '0;
		q_item.n[0]  = ONE;
		q_item.n[4]  = ONE;
		known        = 1'b1;
		unique case (cmd.command)
			CMD_MAP: begin
				q_item.op   = OP_MAP;
				q_item.n[0] = ENTRY_WIDTH'(cmd.coord_x);
				q_item.n[1] = ENTRY_WIDTH'(cmd.coord_y);
				q_item.n[4] = '0;
			end
			CMD_TRANSLATE: begin
				q_item.op   = OP_XFORM;
				q_item.n[2] = from_int(cmd.coord_x);
				q_item.n[5] = from_int(cmd.coord_y);
			end
			CMD_ROTATE: begin
				q_item.op = OP_ROT;
			end
			CMD_SCALE: begin
				q_item.op   = OP_XFORM;
				q_item.n[0] = from_q16(cmd.scale_x);
				q_item.n[4] = from_q16(cmd.scale_y);
			end
			CMD_CONCAT: begin
				q_item.op   = OP_XFORM;
				q_item.n[0] = from_q16(cmd.other_a);
				q_item.n[1] = from_q16(cmd.other_b);
				q_item.n[2] = from_q16(cmd.other_c);
				q_item.n[3] = from_q16(cmd.other_d);
				q_item.n[4] = from_q16(cmd.other_e);
				q_item.n[5] = from_q16(cmd.other_f);
			end
			CMD_IDENTITY: begin
				q_item.op = OP_IDENT;
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	assign q_push = cmd.valid && !q_full && known;

endmodule

/* hw/rtl/aff2d_fifo.sv */
// Two-entry queue of decoded commands between the front end and the back end.
// Depends on aff2d_pkg.
module aff2d_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  aff2d_pkg::queue_item_t push_data,
	output logic                   full,
	input  logic                   pop,
	output aff2d_pkg::queue_item_t pop_data,
	output logic                   empty
);
	import aff2d_pkg::*;

	queue_item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]       wr_ptr_q;
	logic [QPTR_W-1:0]       rd_ptr_q;
	logic [QCNT_W-1:0]       count_q;

	assign full     = count_q == QCNT_W'(QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* hw/rtl/aff2d_cordic.sv */
// Iterative CORDIC unit: one rotation step per cycle, giving the cosine and
// sine of a binary angle in entry format. Depends on aff2d_pkg.
module aff2d_cordic (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [15:0]       angle,
	output logic              done,
	output aff2d_pkg::entry_t cs,
	output aff2d_pkg::entry_t sn
);
	import aff2d_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [STEP_W-1:0]    step_q;
	logic signed [CW-1:0] x_q;
	logic signed [CW-1:0] y_q;
	logic signed [CW-1:0] z_q;
	logic                 flip_q;
	logic                 flip_c;
	logic [15:0]          folded;
	logic signed [CW-1:0] xs;
	logic signed [CW-1:0] ys;
	logic signed [CW-1:0] at;
	logic signed [CW-1:0] x_out;
	logic signed [CW-1:0] y_out;

	assign flip_c = angle[15] ^ angle[14];
	assign folded = flip_c ? (angle ^ 16'h8000) : angle;
	assign xs     = x_q >>> step_q;
	assign ys     = y_q >>> step_q;
	assign at     = CW'(atan_lut(5'(step_q)));
	assign x_out  = x_q >>> (30 - FRAC_BITS);
	assign y_out  = y_q >>> (30 - FRAC_BITS);
	assign cs     = flip_q ? -ENTRY_WIDTH'(x_out) : ENTRY_WIDTH'(x_out);
	assign sn     = flip_q ? -ENTRY_WIDTH'(y_out) : ENTRY_WIDTH'(y_out);
	assign done   = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= !start && busy_q && (step_q == STEP_W'(CORDIC_STEPS - 1));
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= CORDIC_GAIN;
			y_q    <= '0;
			z_q    <= CW'($signed(folded)) <<< 16;
			flip_q <= flip_c;
		end else if (busy_q) begin
			if (!z_q[CW-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

endmodule

/* hw/rtl/aff2d_back.sv */
// Back end: holds the matrix, runs the CORDIC unit and a shared chunked
// multiply-accumulate sequencer, and registers map results for output.
// Depends on aff2d_pkg and aff2d_cordic.
module aff2d_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_empty,
	input  aff2d_pkg::queue_item_t q_item,
	output logic                   q_pop,
	output aff2d_pkg::res_t        res_data,
	output logic                   res_valid,
	input  logic                   res_ready
);
	import aff2d_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_CORDIC = 6'b000010,
		ST_MUL    = 6'b000100,
		ST_DRAIN  = 6'b001000,
		ST_FIN    = 6'b010000,
		ST_OUT    = 6'b100000
	} state_t;

	state_t                  state_q;
	op_t                     op_q;
	entry_t [5:0]            m_q;
	entry_t [5:0]            t_q;
	entry_t [5:0]            n_q;
	logic signed [31:0]      map_q [2];
	logic [1:0]              clip_q;
	logic [2:0]              ent_q;
	logic                    term_q;
	logic [CHUNK_IDX_W-1:0]  chunk_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [PROD_W-1:0]       prod_s1;
	logic [CHUNK_IDX_W-1:0]  sh_s1;
	logic                    neg_s1;
	logic                    vld_s1;
	res_t                    res_q;
	logic                    res_valid_q;

	logic                    is_map;
	logic                    row_sel;
	logic [2:0]              col;
	logic [2:0]              a_idx;
	logic [2:0]              b_idx;
	logic [2:0]              m_rd_idx;
	entry_t                  m_rd;
	entry_t                  b_op;
	logic [ENTRY_WIDTH-1:0]  mag_a;
	logic [ENTRY_WIDTH-1:0]  mag_b;
	logic [NCHUNKS*MUL_CHUNK-1:0] mag_b_pad;
	logic [MUL_CHUNK-1:0]    chunk_b;
	logic [PROD_W-1:0]       prod_c;
	logic [ACC_W-1:0]        term_u;
	logic signed [ACC_W-1:0] addend;
	logic                    next_col2;
	entry_t                  fin_ent;
	logic signed [ACC_W-1:0] map_adj;
	logic signed [ACC_W-1:0] map_sh;
	logic                    map_fits;
	logic signed [31:0]      map_val;
	logic                    last_ent;
	logic                    out_free;
	logic                    cordic_start;
	logic                    cordic_done;
	entry_t                  cordic_cs;
	entry_t                  cordic_sn;

	function automatic entry_t sel6(input entry_t [5:0] v, input logic [2:0] idx);
		entry_t r;
		unique case (idx)
			3'd0: r = v[0];
			3'd1: r = v[1];
			3'd2: r = v[2];
			3'd3: r = v[3];
			3'd4: r = v[4];
			3'd5: r = v[5];
			default: r = '0;
		endcase
		return r;
	endfunction

	assign is_map   = op_q == OP_MAP;
	assign row_sel  = is_map ? ent_q[0] : (ent_q >= 3'd3);
	assign col      = (ent_q >= 3'd3) ? ent_q - 3'd3 : ent_q;
	assign a_idx    = row_sel ? 3'd3 + {2'b0, term_q} : {2'b0, term_q};
	assign b_idx    = is_map ? {2'b0, term_q} : (term_q ? 3'd3 + col : col);
	assign last_ent = is_map ? (ent_q == 3'd1) : (ent_q == 3'd5);

	always_comb begin
		unique case (state_q)
			ST_MUL:  m_rd_idx = a_idx;
			ST_FIN:  m_rd_idx = is_map ? 3'd5 : (last_ent ? 3'd0 : ent_q + 3'd1);
			default: m_rd_idx = 3'd2;
		endcase
	end

	assign m_rd = sel6(m_q, m_rd_idx);
	assign b_op = sel6(n_q, b_idx);

	assign mag_a     = m_rd[ENTRY_WIDTH-1] ? ENTRY_WIDTH'(-m_rd) : m_rd;
	assign mag_b     = b_op[ENTRY_WIDTH-1] ? ENTRY_WIDTH'(-b_op) : b_op;
	assign mag_b_pad = (NCHUNKS * MUL_CHUNK)'(mag_b);
	assign chunk_b   = mag_b_pad[chunk_q * MUL_CHUNK +: MUL_CHUNK];
	assign prod_c    = PROD_W'(mag_a) * PROD_W'(chunk_b);
	assign term_u    = ACC_W'(prod_s1) << (sh_s1 * MUL_CHUNK);

	assign next_col2 = (ent_q == 3'd1) || (ent_q == 3'd4);
	always_comb begin
		if (is_map) begin
			addend = ACC_W'(m_rd);
		end else if (next_col2) begin
			addend = ACC_W'(m_rd) <<< FRAC_BITS;
		end else begin
			addend = '0;
		end
	end

	assign fin_ent  = sat_acc(acc_q >>> FRAC_BITS);
	assign map_adj  = acc_q + (acc_q[ACC_W-1] ? ACC_W'(ONE - 1) : '0);
	assign map_sh   = map_adj >>> FRAC_BITS;
	assign map_fits = (&map_sh[ACC_W-1:31]) || !(|map_sh[ACC_W-1:31]);
	assign map_val  = map_fits ? map_sh[31:0] :
		(map_sh[ACC_W-1] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}});

	assign out_free     = !res_valid_q || res_ready;
	assign q_pop        = (state_q == ST_IDLE) && !q_empty;
	assign cordic_start = q_pop && (q_item.op == OP_ROT);

	aff2d_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_start),
		.angle  (q_item.angle),
		.done   (cordic_done),
		.cs     (cordic_cs),
		.sn     (cordic_sn)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_IDENT;
			m_q         <= IDENT_M;
			ent_q       <= '0;
			term_q      <= 1'b0;
			chunk_q     <= '0;
			vld_s1      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			vld_s1      <= state_q == ST_MUL;
			res_valid_q <= ((state_q == ST_OUT) && out_free) || (res_valid_q && !res_ready);
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						op_q    <= q_item.op;
						ent_q   <= '0;
						term_q  <= 1'b0;
						chunk_q <= '0;
						unique case (q_item.op)
							OP_IDENT: m_q     <= IDENT_M;
							OP_ROT:   state_q <= ST_CORDIC;
							default:  state_q <= ST_MUL;
						endcase
					end
				end
				ST_CORDIC: begin
					if (cordic_done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (chunk_q == CHUNK_IDX_W'(NCHUNKS - 1)) begin
						chunk_q <= '0;
						term_q  <= !term_q;
						if (term_q) begin
							state_q <= ST_DRAIN;
						end
					end else begin
						chunk_q <= chunk_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (last_ent) begin
						if (is_map) begin
							state_q <= ST_OUT;
						end else begin
							m_q     <= {fin_ent, t_q[4:0]};
							state_q <= ST_IDLE;
						end
					end else begin
						ent_q   <= ent_q + 3'd1;
						state_q <= ST_MUL;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			acc_q <= acc_q + (neg_s1 ? -$signed(term_u) : $signed(term_u));
		end
		if (state_q == ST_MUL) begin
			prod_s1 <= prod_c;
			sh_s1   <= chunk_q;
			neg_s1  <= m_rd[ENTRY_WIDTH-1] ^ b_op[ENTRY_WIDTH-1];
		end
		if (q_pop) begin
			n_q   <= q_item.n;
			acc_q <= (q_item.op == OP_MAP) ? ACC_W'(m_rd) : '0;
		end
		if (state_q == ST_CORDIC && cordic_done) begin
			n_q[0] <= cordic_cs;
			n_q[1] <= -cordic_sn;
			n_q[2] <= '0;
			n_q[3] <= cordic_sn;
			n_q[4] <= cordic_cs;
			n_q[5] <= '0;
			acc_q  <= '0;
		end
		if (state_q == ST_FIN) begin
			acc_q <= addend;
			if (is_map) begin
				map_q[ent_q[0]]  <= map_val;
				clip_q[ent_q[0]] <= !map_fits;
			end else begin
				t_q[ent_q] <= fin_ent;
			end
		end
		if (state_q == ST_OUT && out_free) begin
			res_q.out_x   <= map_q[0];
			res_q.out_y   <= map_q[1];
			res_q.clipped <= |clip_q;
		end
	end

	assign res_data  = res_q;
	assign res_valid = res_valid_q;

endmodule

/* sim/affine_transform_2d_engine_tb.sv */
// Testbench for the 2D affine transform engine: drives directed commands and
// random bursts, stalls the result channel, and checks every map result against
// a predictor built on the aff2d_pkg constants. Depends on aff2d_pkg and aff2d_if.
module affine_transform_2d_engine_tb;
	import aff2d_pkg::*;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic [2:0]         command;
		logic signed [15:0] coord_x;
		logic signed [15:0] coord_y;
		logic [15:0]        angle;
		logic signed [31:0] scale_x;
		logic signed [31:0] scale_y;
		logic signed [31:0] other [6];
	} cmd_txn_t;

	class affine_scoreboard;
		entry_t mat [6];
		res_t   pending [$];
		int     errors;

		function new();
			errors = 0;
			load_identity();
		endfunction

		function void load_identity();
			foreach (mat[i]) mat[i] = '0;
			mat[0] = ONE;
			mat[4] = ONE;
		endfunction

		function entry_t clamp_entry(wide_t v);
			wide_t hi;
			wide_t lo;
			hi = wide_t'(ENT_MAX);
			lo = wide_t'(ENT_MIN);
			if (v > hi) return ENT_MAX;
			if (v < lo) return ENT_MIN;
			return entry_t'(v);
		endfunction

		function void post_multiply(entry_t n [6]);
			entry_t m [6];
			wide_t  s;
			m = mat;
			for (int r = 0; r < 2; r++) begin
				for (int c = 0; c < 3; c++) begin
					s = wide_t'(m[3*r]) * wide_t'(n[c]) + wide_t'(m[3*r+1]) * wide_t'(n[3+c]);
					if (c == 2) s = s + (wide_t'(m[3*r+2]) <<< FRAC_BITS);
					mat[3*r+c] = clamp_entry(s >>> FRAC_BITS);
				end
			end
		endfunction

		function void rotation(logic [15:0] ang, output entry_t cs, output entry_t sn);
			logic signed [63:0] atan_tab [16];
			logic signed [63:0] x, y, z, t;
			logic        flip;
			logic [15:0] folded;
			atan_tab = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
				64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
				64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
				64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};
			flip = (ang >= 16'd16384) && (ang < 16'd49152);
			folded = flip ? (ang ^ 16'h8000) : ang;
			z = 64'(signed'(folded)) <<< 16;
			x = 64'sd652032874;
			y = 0;
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				if (z >= 0) begin
					t = x - (y >>> i);
					y = y + (x >>> i);
					z = z - atan_tab[i];
				end else begin
					t = x + (y >>> i);
					y = y - (x >>> i);
					z = z + atan_tab[i];
				end
				x = t;
			end
			x = x >>> (30 - FRAC_BITS);
			y = y >>> (30 - FRAC_BITS);
			if (flip) begin
				x = -x;
				y = -y;
			end
			cs = clamp_entry(wide_t'(x));
			sn = clamp_entry(wide_t'(y));
		endfunction

		function void note(cmd_txn_t tr);
			entry_t n [6];
			entry_t cs, sn;
			wide_t  s;
			res_t   r;
			foreach (n[i]) n[i] = '0;
			n[0] = ONE;
			n[4] = ONE;
			case (tr.command)
				CMD_MAP: begin
					r.clipped = 1'b0;
					for (int i = 0; i < 2; i++) begin
						s = wide_t'(tr.coord_x) * wide_t'(mat[3*i])
							+ wide_t'(tr.coord_y) * wide_t'(mat[3*i+1]) + wide_t'(mat[3*i+2]);
						if (s < 0) s = s + wide_t'(ONE) - 1;
						s = s >>> FRAC_BITS;
						if (s > 128'sd2147483647) begin
							s = 128'sd2147483647;
							r.clipped = 1'b1;
						end else if (s < -128'sd2147483648) begin
							s = -128'sd2147483648;
							r.clipped = 1'b1;
						end
						if (i == 0) r.out_x = 32'(s);
						else r.out_y = 32'(s);
					end
					pending.push_back(r);
				end
				CMD_TRANSLATE: begin
					n[2] = clamp_entry(wide_t'(tr.coord_x) <<< FRAC_BITS);
					n[5] = clamp_entry(wide_t'(tr.coord_y) <<< FRAC_BITS);
					post_multiply(n);
				end
				CMD_ROTATE: begin
					rotation(tr.angle, cs, sn);
					n[0] = cs;
					n[1] = clamp_entry(-wide_t'(sn));
					n[3] = sn;
					n[4] = cs;
					post_multiply(n);
				end
				CMD_SCALE: begin
					n[0] = clamp_entry(wide_t'(tr.scale_x) <<< (FRAC_BITS - 16));
					n[4] = clamp_entry(wide_t'(tr.scale_y) <<< (FRAC_BITS - 16));
					post_multiply(n);
				end
				CMD_CONCAT: begin
					for (int i = 0; i < 6; i++)
						n[i] = clamp_entry(wide_t'(tr.other[i]) <<< (FRAC_BITS - 16));
					post_multiply(n);
				end
				CMD_IDENTITY: load_identity();
				default: ;
			endcase
		endfunction

		function void check(res_t got);
			res_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result x=%0d y=%0d clipped=%0b", $time,
					got.out_x, got.out_y, got.clipped);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.out_x !== want.out_x) begin
				$display("%0t: out_x expected %0d actual %0d", $time, want.out_x, got.out_x);
				errors++;
			end
			if (got.out_y !== want.out_y) begin
				$display("%0t: out_y expected %0d actual %0d", $time, want.out_y, got.out_y);
				errors++;
			end
			if (got.clipped !== want.clipped) begin
				$display("%0t: clipped expected %0b actual %0b", $time, want.clipped,
					got.clipped);
				errors++;
			end
		endfunction
	endclass

	localparam int WATCHDOG_LIMIT = 4000;

	logic clk;
	logic arst_n;
	aff2d_cmd_if cmd_bus();
	aff2d_res_if res_bus();
	affine_transform_2d_engine u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus.sink),
		.res    (res_bus.source)
	);

	affine_scoreboard sb;
	int  idle_cycles;
	bit  hold_request;
	bit  long_hold_done;

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cmd_txn_t tr;
		res_t     r;
		bit       seen;
		if (arst_n) begin
			seen = 1'b0;
			if (cmd_bus.valid && cmd_bus.ready) begin
				tr.command = cmd_bus.command;
				tr.coord_x = cmd_bus.coord_x;
				tr.coord_y = cmd_bus.coord_y;
				tr.angle   = cmd_bus.angle;
				tr.scale_x = cmd_bus.scale_x;
				tr.scale_y = cmd_bus.scale_y;
				tr.other   = '{cmd_bus.other_a, cmd_bus.other_b, cmd_bus.other_c,
					cmd_bus.other_d, cmd_bus.other_e, cmd_bus.other_f};
				sb.note(tr);
				seen = 1'b1;
			end
			if (res_bus.valid && res_bus.ready) begin
				r.out_x   = res_bus.out_x;
				r.out_y   = res_bus.out_y;
				r.clipped = res_bus.clipped;
				sb.check(r);
				seen = 1'b1;
			end
			idle_cycles <= seen ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired", $time);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		int hold_left;
		int mode;
		int mode_left;
		hold_left = 0;
		mode = 0;
		mode_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request && !long_hold_done) begin
				hold_left = 500;
				long_hold_done = 1;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(10, 80);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				res_bus.ready <= 1'b0;
			end else begin
				case (mode)
					0: res_bus.ready <= 1'b1;
					1: res_bus.ready <= ($urandom_range(0, 3) != 0);
					2: res_bus.ready <= ($urandom_range(0, 3) == 0);
					default: res_bus.ready <= (mode_left % 7 < 4);
				endcase
			end
		end
	end

	function automatic cmd_txn_t blank_txn(logic [2:0] c);
		cmd_txn_t tr;
		tr.command = c;
		tr.coord_x = 16'($urandom);
		tr.coord_y = 16'($urandom);
		tr.angle   = 16'($urandom);
		tr.scale_x = 32'($urandom);
		tr.scale_y = 32'($urandom);
		foreach (tr.other[i]) tr.other[i] = 32'($urandom);
		return tr;
	endfunction

	function automatic logic signed [31:0] mild_q16();
		return 32'sd65536 + 32'(signed'(17'($urandom))) - 32'sd65536;
	endfunction

	task automatic send(cmd_txn_t tr);
		cmd_bus.valid   <= 1'b1;
		cmd_bus.command <= tr.command;
		cmd_bus.coord_x <= tr.coord_x;
		cmd_bus.coord_y <= tr.coord_y;
		cmd_bus.angle   <= tr.angle;
		cmd_bus.scale_x <= tr.scale_x;
		cmd_bus.scale_y <= tr.scale_y;
		cmd_bus.other_a <= tr.other[0];
		cmd_bus.other_b <= tr.other[1];
		cmd_bus.other_c <= tr.other[2];
		cmd_bus.other_d <= tr.other[3];
		cmd_bus.other_e <= tr.other[4];
		cmd_bus.other_f <= tr.other[5];
		do @(posedge clk); while (!cmd_bus.ready);
		@(negedge clk);
	endtask

	task automatic pause(int cycles);
		if (cycles > 0) begin
			cmd_bus.valid <= 1'b0;
			repeat (cycles) @(negedge clk);
		end
	endtask

	task automatic send_map(logic signed [15:0] x, logic signed [15:0] y);
		cmd_txn_t tr;
		tr = blank_txn(CMD_MAP);
		tr.coord_x = x;
		tr.coord_y = y;
		send(tr);
	endtask

	task automatic directed_items();
		cmd_txn_t tr;
		logic [15:0] angles [7];
		angles = '{16'd0, 16'd16383, 16'd16384, 16'd32768, 16'd49151, 16'd49152, 16'd65535};
		send_map(-16'sd32768, 16'sd32767);
		send_map(16'sd0, 16'sd0);
		tr = blank_txn(CMD_TRANSLATE);
		tr.coord_x = 16'sh7FFF;
		tr.coord_y = 16'sh8000;
		send(tr);
		send_map(16'sd32767, -16'sd1);
		foreach (angles[i]) begin
			tr = blank_txn(CMD_ROTATE);
			tr.angle = angles[i];
			send(tr);
		end
		send_map(16'sd1234, -16'sd4321);
		tr = blank_txn(CMD_SCALE);
		tr.scale_x = 32'sh7FFFFFFF;
		tr.scale_y = 32'sh80000000;
		send(tr);
		send_map(-16'sd32768, -16'sd32768);
		tr = blank_txn(CMD_CONCAT);
		tr.other = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
			32'sh80000000, 32'sh00000000, 32'sh80000000};
		send(tr);
		send_map(16'sd32767, 16'sd32767);
		send(blank_txn(3'd6));
		send(blank_txn(3'd7));
		send(blank_txn(CMD_IDENTITY));
		send_map(-16'sd7, 16'sd9);
	endtask

	task automatic random_items(int count);
		cmd_txn_t tr;
		int pick;
		int burst;
		burst = 0;
		for (int k = 0; k < count; k++) begin
			if (k == count / 2) hold_request = 1;
			if (burst == 0) begin
				burst = $urandom_range(1, 20);
				if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 40));
			end
			burst--;
			pick = $urandom_range(0, 99);
			if (pick < 45) tr = blank_txn(CMD_MAP);
			else if (pick < 55) tr = blank_txn(CMD_TRANSLATE);
			else if (pick < 65) tr = blank_txn(CMD_ROTATE);
			else if (pick < 75) tr = blank_txn(CMD_SCALE);
			else if (pick < 85) tr = blank_txn(CMD_CONCAT);
			else if (pick < 95) tr = blank_txn(CMD_IDENTITY);
			else tr = blank_txn(3'($urandom_range(6, 7)));
			if ($urandom_range(0, 3) != 0) begin
				tr.scale_x = mild_q16();
				tr.scale_y = mild_q16();
				foreach (tr.other[i]) tr.other[i] = mild_q16();
			end
			send(tr);
		end
		cmd_bus.valid <= 1'b0;
	endtask

	initial begin
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		idle_cycles = 0;
		hold_request = 0;
		long_hold_done = 0;
		cmd_bus.valid = 1'b0;
		cmd_bus.command = CMD_IDENTITY;
		cmd_bus.coord_x = '0;
		cmd_bus.coord_y = '0;
		cmd_bus.angle = '0;
		cmd_bus.scale_x = '0;
		cmd_bus.scale_y = '0;
		cmd_bus.other_a = '0;
		cmd_bus.other_b = '0;
		cmd_bus.other_c = '0;
		cmd_bus.other_d = '0;
		cmd_bus.other_e = '0;
		cmd_bus.other_f = '0;
		res_bus.ready = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		directed_items();
		random_items(400);
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (sb.errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
